[design/bchd_pkg.sv]
// ----------------------------------------------------------------------------
// bchd_pkg: button click and hold detector package
// Types, register indexes, reset values and field widths shared by the
// interfaces and the detector.
// ----------------------------------------------------------------------------
package bchd_pkg;

  localparam int MAX_CLICKS_DEF = 15;
  localparam int COUNT_FIELD_W  = 4;
  localparam int TIME_W         = 32;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_MS      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_MS   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOSED_LEVEL = 2'd3;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_MS_RST = 16'd50;
  localparam logic [CFG_DATA_W-1:0] HOLD_MS_RST     = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] RELEASE_MS_RST  = 16'd500;
  localparam logic                  CLOSED_LVL_RST  = 1'b0;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_HELD     = 2'd2,
    MODE_RELEASED = 2'd3
  } mode_t;

endpackage

[design/bchd_in_if.sv]
// ----------------------------------------------------------------------------
// bchd_in_if: poll channel
// Valid/ready channel carrying one poll of the button pin and the time.
// ----------------------------------------------------------------------------
interface bchd_in_if
  import bchd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              raw_level;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output raw_level, output now_ms, input ready);
  modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

[design/bchd_out_if.sv]
// ----------------------------------------------------------------------------
// bchd_out_if: result channel
// Valid/ready channel carrying the event flags and counts of one poll.
// ----------------------------------------------------------------------------
interface bchd_out_if
  import bchd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     is_pressed;
  logic                     click_event;
  logic                     held_event;
  logic                     hold_active;
  logic                     release_event;
  logic [COUNT_FIELD_W-1:0] run_clicks;
  logic [COUNT_FIELD_W-1:0] run_end_clicks;
  logic [COUNT_FIELD_W-1:0] clicks_before_held;
  logic [COUNT_FIELD_W-1:0] clicks_before_hold;

  modport source (
    output valid, output is_pressed, output click_event, output held_event,
    output hold_active, output release_event, output run_clicks,
    output run_end_clicks, output clicks_before_held, output clicks_before_hold,
    input ready
  );
  modport sink (
    input valid, input is_pressed, input click_event, input held_event,
    input hold_active, input release_event, input run_clicks,
    input run_end_clicks, input clicks_before_held, input clicks_before_hold,
    output ready
  );
endinterface

[design/button_click_hold_detector.sv]
// ----------------------------------------------------------------------------
// button_click_hold_detector: debounced multi-click and hold detector
// Debounces polled button samples and reports clicks, holds, releases and
// the end of click runs, one result transaction per poll transaction.
// ----------------------------------------------------------------------------
// Each poll transaction updates the debounce and mode registers in the cycle
// it is accepted and loads its result into the output register, so results
// appear in the cycle after the poll and a new poll is taken in every cycle
// while no result is stalled. The only stall comes from the output register:
// a poll is refused only while a result is waiting and out_if.ready is low.
// The rate of one poll per cycle holds as the mode state updates on each poll.
// Configuration writes take effect at once and should be made while idle.
module button_click_hold_detector
  import bchd_pkg::*;
#(
  parameter int MAX_CLICKS = MAX_CLICKS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  bchd_in_if.sink                in_if,
  bchd_out_if.source             out_if,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_CLICKS + 1);
  localparam int EXT_W = (CNT_W > COUNT_FIELD_W) ? CNT_W : COUNT_FIELD_W;

  logic [CFG_DATA_W-1:0] debounce_ms_r;
  logic [CFG_DATA_W-1:0] hold_ms_r;
  logic [CFG_DATA_W-1:0] release_ms_r;
  logic                  closed_level_r;

  logic              previous_raw_r;
  logic [TIME_W-1:0] last_change_r;
  logic [TIME_W-1:0] last_change_nxt;
  logic              pressed_r;
  logic              pressed_nxt;
  mode_t             mode_r;
  mode_t             mode_nxt;
  logic [TIME_W-1:0] mode_timer_r;
  logic [TIME_W-1:0] mode_timer_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  logic              in_fire;
  logic              expired;
  logic [TIME_W-1:0] stable_time;
  logic [TIME_W-1:0] mode_time;
  logic              clicked;
  logic              held;
  logic              hold;
  logic              released;
  logic [CNT_W-1:0]  end_cnt;
  logic [CNT_W-1:0]  held_cnt;
  logic [CNT_W-1:0]  hold_cnt;

  logic [EXT_W-1:0] count_ext;
  logic [EXT_W-1:0] end_ext;
  logic [EXT_W-1:0] held_ext;
  logic [EXT_W-1:0] hold_ext;

  logic                     out_valid_r;
  logic                     is_pressed_r;
  logic                     click_event_r;
  logic                     held_event_r;
  logic                     hold_active_r;
  logic                     release_event_r;
  logic [COUNT_FIELD_W-1:0] run_clicks_r;
  logic [COUNT_FIELD_W-1:0] run_end_clicks_r;
  logic [COUNT_FIELD_W-1:0] clicks_before_held_r;
  logic [COUNT_FIELD_W-1:0] clicks_before_hold_r;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r  <= DEBOUNCE_MS_RST;
      hold_ms_r      <= HOLD_MS_RST;
      release_ms_r   <= RELEASE_MS_RST;
      closed_level_r <= CLOSED_LVL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_MS:  debounce_ms_r  <= cfg_wdata;
        REG_HOLD_MS:      hold_ms_r      <= cfg_wdata;
        REG_RELEASE_MS:   release_ms_r   <= cfg_wdata;
        REG_CLOSED_LEVEL: closed_level_r <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  assign last_change_nxt = (in_if.raw_level != previous_raw_r) ? in_if.now_ms : last_change_r;
  assign stable_time     = in_if.now_ms - last_change_nxt;
  assign expired         = stable_time > TIME_W'(debounce_ms_r);
  assign mode_time       = in_if.now_ms - mode_timer_r;

  always_comb begin
    mode_nxt       = mode_r;
    mode_timer_nxt = mode_timer_r;
    count_nxt      = count_r;
    pressed_nxt    = pressed_r;
    clicked        = 1'b0;
    held           = 1'b0;
    hold           = 1'b0;
    released       = 1'b0;
    end_cnt        = '0;
    held_cnt       = '0;
    hold_cnt       = '0;
    if (expired) begin
      pressed_nxt = in_if.raw_level ^ closed_level_r;
      if (pressed_nxt) begin
        unique case (mode_r)
          MODE_IDLE: begin
            mode_nxt       = MODE_PRESSED;
            mode_timer_nxt = in_if.now_ms;
            count_nxt      = CNT_W'(1);
            clicked        = 1'b1;
          end
          MODE_PRESSED: begin
            if (mode_time >= TIME_W'(hold_ms_r)) begin
              mode_nxt       = MODE_HELD;
              mode_timer_nxt = in_if.now_ms;
              held           = 1'b1;
              held_cnt       = count_r - CNT_W'(1);
            end
          end
          MODE_HELD: begin
            hold     = 1'b1;
            hold_cnt = count_r - CNT_W'(1);
          end
          MODE_RELEASED: begin
            mode_nxt       = MODE_PRESSED;
            mode_timer_nxt = in_if.now_ms;
            count_nxt      = count_r + CNT_W'(1);
            clicked        = 1'b1;
          end
          default: ;
        endcase
      end else begin
        unique case (mode_r)
          MODE_IDLE: ;
          MODE_PRESSED: begin
            if (count_r == CNT_W'(MAX_CLICKS)) begin
              mode_nxt  = MODE_IDLE;
              end_cnt   = count_r;
              count_nxt = '0;
            end else begin
              mode_nxt = MODE_RELEASED;
            end
            mode_timer_nxt = in_if.now_ms;
            released       = 1'b1;
          end
          MODE_HELD: begin
            mode_nxt       = MODE_IDLE;
            mode_timer_nxt = in_if.now_ms;
            count_nxt      = '0;
            released       = 1'b1;
          end
          MODE_RELEASED: begin
            if (mode_time >= TIME_W'(release_ms_r)) begin
              mode_nxt       = MODE_IDLE;
              mode_timer_nxt = in_if.now_ms;
              end_cnt        = count_r;
              count_nxt      = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      previous_raw_r <= 1'b0;
      last_change_r  <= '0;
      pressed_r      <= 1'b0;
      mode_r         <= MODE_IDLE;
      mode_timer_r   <= '0;
      count_r        <= '0;
    end else if (in_fire) begin
      previous_raw_r <= in_if.raw_level;
      last_change_r  <= last_change_nxt;
      pressed_r      <= pressed_nxt;
      mode_r         <= mode_nxt;
      mode_timer_r   <= mode_timer_nxt;
      count_r        <= count_nxt;
    end
  end

  assign count_ext = EXT_W'(count_nxt);
  assign end_ext   = EXT_W'(end_cnt);
  assign held_ext  = EXT_W'(held_cnt);
  assign hold_ext  = EXT_W'(hold_cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      is_pressed_r         <= pressed_nxt;
      click_event_r        <= clicked;
      held_event_r         <= held;
      hold_active_r        <= hold;
      release_event_r      <= released;
      run_clicks_r         <= count_ext[COUNT_FIELD_W-1:0];
      run_end_clicks_r     <= end_ext[COUNT_FIELD_W-1:0];
      clicks_before_held_r <= held_ext[COUNT_FIELD_W-1:0];
      clicks_before_hold_r <= hold_ext[COUNT_FIELD_W-1:0];
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.is_pressed         = is_pressed_r;
  assign out_if.click_event        = click_event_r;
  assign out_if.held_event         = held_event_r;
  assign out_if.hold_active        = hold_active_r;
  assign out_if.release_event      = release_event_r;
  assign out_if.run_clicks         = run_clicks_r;
  assign out_if.run_end_clicks     = run_end_clicks_r;
  assign out_if.clicks_before_held = clicks_before_held_r;
  assign out_if.clicks_before_hold = clicks_before_hold_r;

  a_click_release_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !(out_if.click_event && out_if.release_event))
    else $error("click and release flagged in the same result");

  a_held_is_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.held_event || out_if.hold_active)) |-> out_if.is_pressed)
    else $error("hold reported while the button is not pressed");

  a_run_end_released: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.run_end_clicks != '0)) |-> !out_if.is_pressed)
    else $error("click run ended while the button is pressed");

  a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.ready && !in_fire) |=> !out_if.valid)
    else $error("result register stayed full without a new poll");

endmodule
